/* hw/rtl/mamm_pkg.sv */
// Moving-average moisture mapper: shared types and constants.
// Holds field widths, register indexes, sequencer states and the
// divider request/response and ring request structs. Depends on nothing.
package mamm_pkg;

  localparam int LEVEL_W   = 12;
  localparam int PCT_W     = 15;
  localparam int QUO_W     = 15;
  localparam int DVD_W     = LEVEL_W + QUO_W;
  localparam int CNT_W     = $clog2(QUO_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [PCT_W-1:0]     FULL_SCALE = 15'd25600;
  localparam logic [LEVEL_W-1:0]   DRY_RESET  = 12'd4095;
  localparam logic [LEVEL_W-1:0]   WET_RESET  = 12'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_DRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MAP,
    ST_PCT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [LEVEL_W-1:0] wr_data;
  } ring_req_t;

endpackage

/* hw/rtl/mamm_ring.sv */
// Sample ring: WINDOW-entry memory with its own write slot and fill flag.
// Reads and writes always address the oldest slot; a write advances it.
// Depends on mamm_pkg.
module mamm_ring #(
  parameter int WINDOW = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mamm_pkg::ring_req_t          req,
  output logic [mamm_pkg::LEVEL_W-1:0] rd_data
);
  import mamm_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [LEVEL_W-1:0] mem [WINDOW];
  logic [LEVEL_W-1:0] rd_q_r;
  logic               rd_vld_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      full_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_vld_r <= full_r;
      end
      if (req.wr_en) begin
        if (slot_r == LAST_SLOT) begin
          slot_r <= '0;
          full_r <= 1'b1;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[slot_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[slot_r];
    end
  end

  // never-written slots read as zero
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

/* hw/rtl/mamm_div.sv */
// Restoring divider: one quotient bit per cycle.
// The dividend's upper LEVEL_W bits must be below the divisor.
// Depends on mamm_pkg.
module mamm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mamm_pkg::div_req_t req,
  output mamm_pkg::div_rsp_t rsp
);
  import mamm_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [LEVEL_W-1:0] dsr_r;

  logic [LEVEL_W:0]   trial;
  logic [LEVEL_W:0]   trial_diff;
  logic               fits;

  assign trial      = {rem_r, quo_r[QUO_W-1]};
  assign fits       = trial >= {1'b0, dsr_r};
  assign trial_diff = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[DVD_W-1:QUO_W];
      quo_r <= req.dividend[QUO_W-1:0];
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial_diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(req.start) |-> rem_r < dsr_r)
    else $error("divider remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r && cnt_r == CNT_W'(QUO_W))
    else $error("divider did not start");

endmodule

/* hw/rtl/moving_average_moisture_mapper.sv */
// Moving-average moisture mapper, top level: sequencer, running sum,
// calibration registers and output register.
// Depends on mamm_pkg, mamm_ring and mamm_div.
//
// Input channel: in_valid/in_stall carries one 12-bit sample. The block
// stalls its input while it works on an item.
// Result channel: out_valid/out_stall carries the raw sample, the truncated
// window average and the moisture percentage times 256.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 dry level, 1 wet
// level, others ignored) and cfg_wdata; cfg_ready is always high.
// The window average comes from a reciprocal multiply; one 15-step
// divider forms the interpolated percentage, which is used only when
// the average lies strictly between the calibration levels; at or
// beyond a level the percentage is 0 or full scale with no division.
// The next sample is taken once the result is written out.
// A finished result sits in the output register; the block takes the next
// sample meanwhile and waits before writing its own result only while that
// register is still stalled.
// Reset empties the ring (old entries read as zero), clears the running sum
// and restores dry level 4095 and wet level 0.
module moving_average_moisture_mapper #(
  parameter int WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mamm_pkg::LEVEL_W-1:0]     in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mamm_pkg::LEVEL_W-1:0]     out_raw_sample,
  output logic [mamm_pkg::LEVEL_W-1:0]     out_smoothed_level,
  output logic [mamm_pkg::PCT_W-1:0]       out_moisture_percent,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mamm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mamm_pkg::LEVEL_W-1:0]     cfg_wdata
);
  import mamm_pkg::*;

  localparam int SUM_W     = $clog2(WINDOW * ((1 << LEVEL_W) - 1) + 1);
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LEVEL_W-1:0] sample_r, sample_nxt;
  logic [LEVEL_W-1:0] avg_r, avg_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic [LEVEL_W-1:0] dry_r, wet_r;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_raw_r, out_raw_nxt;
  logic [LEVEL_W-1:0] out_avg_r, out_avg_nxt;
  logic [PCT_W-1:0]   out_pct_r, out_pct_nxt;

  ring_req_t          ring_req;
  logic [LEVEL_W-1:0] ring_rd_data;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [LEVEL_W-1:0] dry_gap;
  logic [DVD_W-1:0]   scaled_gap;
  logic [PROD_W-1:0]  avg_prod;

  mamm_ring #(.WINDOW(WINDOW)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  mamm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign dry_gap    = dry_r - avg_r;
  assign scaled_gap = DVD_W'(dry_gap) * DVD_W'(FULL_SCALE);
  assign avg_prod   = PROD_W'(sum_r) * PROD_W'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      dry_r       <= DRY_RESET;
      wet_r       <= WET_RESET;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DRY: dry_r <= cfg_wdata;
          CFG_WET: wet_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    avg_r     <= avg_nxt;
    pct_r     <= pct_nxt;
    out_raw_r <= out_raw_nxt;
    out_avg_r <= out_avg_nxt;
    out_pct_r <= out_pct_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    sum_nxt          = sum_r;
    sample_nxt       = sample_r;
    avg_nxt          = avg_r;
    pct_nxt          = pct_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_raw_nxt      = out_raw_r;
    out_avg_nxt      = out_avg_r;
    out_pct_nxt      = out_pct_r;
    ring_req         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = scaled_gap;
    div_req.divisor  = dry_r - wet_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt     = in_sample;
          ring_req.rd_en = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        sum_nxt          = sum_r - SUM_W'(ring_rd_data) + SUM_W'(sample_r);
        ring_req.wr_en   = 1'b1;
        ring_req.wr_data = sample_r;
        state_nxt        = ST_SUM;
      end
      ST_SUM: begin
        avg_nxt   = avg_prod[AVG_SHIFT +: LEVEL_W];
        state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (avg_r >= dry_r) begin
          pct_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (avg_r <= wet_r) begin
          pct_nxt   = FULL_SCALE;
          state_nxt = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_PCT;
        end
      end
      ST_PCT: begin
        if (div_rsp.done) begin
          pct_nxt   = div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = sample_r;
          out_avg_nxt   = avg_r;
          out_pct_nxt   = pct_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall             = state_r != ST_IDLE;
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_raw_sample       = out_raw_r;
  assign out_smoothed_level   = out_avg_r;
  assign out_moisture_percent = out_pct_r;

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= FULL_SCALE)
    else $error("moisture percentage out of range");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for moving_average_moisture_mapper: a queue-fed
// sample driver, a result monitor and an in-line smoothing/mapping predictor.
// Depends on mamm_pkg and the moving_average_moisture_mapper RTL.
module testbench;
  import mamm_pkg::*;

  localparam int WIN        = 16;
  localparam int N_PHASES   = 8;
  localparam int PHASE_LEN  = 188;
  localparam int MAX_CYCLES = 1000000;
  localparam int MAX_SHOWN  = 10;
  localparam int SETTLE     = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic [LEVEL_W-1:0] raw;
    logic [LEVEL_W-1:0] level;
    logic [PCT_W-1:0]   pct;
  } reading_t;

  typedef enum int {SPAN_FULL, SPAN_BAND, SPAN_LOW, SPAN_HIGH, SPAN_EDGE} span_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_raw_sample;
  logic [LEVEL_W-1:0]   out_smoothed_level;
  logic [PCT_W-1:0]     out_moisture_percent;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEVEL_W-1:0]   cfg_wdata = '0;

  logic [LEVEL_W-1:0] pending_samples[$];
  reading_t           expected_readings[$];
  logic               in_taken = 1'b0;

  logic [LEVEL_W-1:0] ring_q [WIN];
  int                 level_sum = 0;
  int                 slot_q = 0;
  logic [LEVEL_W-1:0] dry_q = DRY_RESET;
  logic [LEVEL_W-1:0] wet_q = WET_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int failures = 0;
  int samples_sent = 0;
  int readings_seen = 0;
  int cfg_writes = 0;
  int cycles = 0;

  int dry_tab [N_PHASES] = '{4095, 3000, 0, 2048, 2000, 4095, 3500, 2500};
  int wet_tab [N_PHASES] = '{0, 1200, 4095, 2048, 1998, 0, 500, 100};
  int gap_tab [N_PHASES] = '{0, 51, 0, 15, 51, 0, 15, 0};
  int stl_tab [N_PHASES] = '{0, 0, 51, 15, 0, 51, 15, 0};

  moving_average_moisture_mapper #(.WINDOW(WIN)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_raw_sample       (out_raw_sample),
    .out_smoothed_level   (out_smoothed_level),
    .out_moisture_percent (out_moisture_percent),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < WIN; i++) ring_q[i] = '0;
  end

  function automatic reading_t smooth_and_map(input logic [LEVEL_W-1:0] s);
    reading_t r;
    int       avg;
    int       span;
    int       num;
    level_sum = level_sum - int'(ring_q[slot_q]) + int'(s);
    ring_q[slot_q] = s;
    slot_q = (slot_q == WIN - 1) ? 0 : slot_q + 1;
    avg = level_sum / WIN;
    r.raw = s;
    r.level = LEVEL_W'(avg);
    if (avg >= int'(dry_q)) begin
      r.pct = '0;
    end else if (avg <= int'(wet_q)) begin
      r.pct = FULL_SCALE;
    end else begin
      span = int'(dry_q) - int'(wet_q);
      num = (int'(dry_q) - avg) * int'(FULL_SCALE);
      r.pct = PCT_W'(num / span);
    end
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_sample(input span_t mode, input int lo,
                                                     input int hi);
    int v;
    case (mode)
      SPAN_BAND: v = $urandom_range(hi, lo);
      SPAN_LOW:  v = $urandom_range(48, 0);
      SPAN_HIGH: v = $urandom_range(4095, 4047);
      SPAN_EDGE: begin
        v = (($urandom_range(1, 0) == 1) ? hi : lo) + $urandom_range(48, 0) - 24;
      end
      default:   v = $urandom_range(4095, 0);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return LEVEL_W'(v);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_readings.size());
      $display("moving_average_moisture_mapper verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_readings.push_back(smooth_and_map(in_sample));
      samples_sent++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_writes++;
      if (cfg_index == CFG_DRY) dry_q = cfg_wdata;
      else if (cfg_index == CFG_WET) wet_q = cfg_wdata;
    end
  end

  always @(negedge clk) begin : drive_proc
    logic               nxt_valid;
    logic [LEVEL_W-1:0] nxt_sample;
    nxt_valid = in_valid;
    nxt_sample = in_sample;
    if (in_valid && in_taken) nxt_valid = 1'b0;
    if (rst_n && !nxt_valid && pending_samples.size() > 0 &&
        $urandom_range(99, 0) >= send_idle_pct) begin
      nxt_valid = 1'b1;
      nxt_sample = pending_samples.pop_front();
    end
    in_valid <= nxt_valid;
    in_sample <= nxt_sample;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99, 0) < recv_stall_pct);
  end

  always @(posedge clk) begin : watch_proc
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        failures++;
        $display("unexpected result raw=%0d level=%0d pct=%0d", out_raw_sample,
                 out_smoothed_level, out_moisture_percent);
      end else begin
        want = expected_readings.pop_front();
        if (out_raw_sample !== want.raw || out_smoothed_level !== want.level ||
            out_moisture_percent !== want.pct) begin
          failures++;
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch at result %0d: raw %0d/%0d level %0d/%0d pct %0d/%0d",
                     readings_seen, want.raw, out_raw_sample, want.level,
                     out_smoothed_level, want.pct, out_moisture_percent);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
  endtask

  initial begin : stim_proc
    span_t mode;
    int    run_left;
    int    lo;
    int    hi;
    int    group;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (pending_samples[i]) pending_samples.delete();
    pending_samples.push_back(12'd0);
    pending_samples.push_back(12'd4095);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    repeat (WIN) pending_samples.push_back(12'd4095);
    repeat (4) pending_samples.push_back(12'd0);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      repeat (SETTLE) @(posedge clk);
      if (p > 0) begin
        write_reg(CFG_DRY, LEVEL_W'(dry_tab[p]));
        write_reg(CFG_WET, LEVEL_W'(wet_tab[p]));
      end
      if (p == 2) begin
        write_reg(CFG_SPARE_LO, LEVEL_W'($urandom_range(4095, 0)));
        write_reg(CFG_SPARE_HI, LEVEL_W'($urandom_range(4095, 0)));
      end
      send_idle_pct = gap_tab[p];
      recv_stall_pct = stl_tab[p];
      lo = (dry_tab[p] < wet_tab[p]) ? dry_tab[p] : wet_tab[p];
      hi = (dry_tab[p] < wet_tab[p]) ? wet_tab[p] : dry_tab[p];
      run_left = 0;
      mode = SPAN_FULL;
      group = 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(40, 1);
          case ($urandom_range(9, 0))
            0, 1:    mode = SPAN_FULL;
            2:       mode = SPAN_LOW;
            3:       mode = SPAN_HIGH;
            4, 5:    mode = SPAN_EDGE;
            default: mode = SPAN_BAND;
          endcase
        end
        run_left--;
        pending_samples.push_back(pick_sample(mode, lo, hi));
        if (p == 3) begin
          if (group == 0) group = $urandom_range(6, 1);
          group--;
          if (group == 0) drain();
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (expected_readings.size() != 0) failures++;
    $display("covered %0d samples, %0d results, %0d register writes over %0d phases",
             samples_sent, readings_seen, cfg_writes, N_PHASES);
    $display("calibration: default, typical, swapped, equal, narrow span; %0d mismatches",
             mismatches);
    if (failures == 0) begin
      $display("moving_average_moisture_mapper verification clean");
    end else begin
      $display("moving_average_moisture_mapper verification failed");
    end
    $finish;
  end

endmodule
